[hdl/rlts_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// rlts_pkg
// Shared types, constants and helpers of the region LOD tick scheduler.
// ---------------------------------------------------------------------------
package rlts_pkg;

  localparam int MAX_REGIONS_DEF = 1024;

  localparam int SIZE_W = 24;
  localparam int EXT_W  = 28;
  localparam int RAD_W  = 28;
  localparam int PER_W  = 32;
  localparam int TICK_W = 64;
  localparam int CEN_W  = 29;
  localparam int NUM_W  = 29;
  localparam int HASH_W = 32;
  localparam int RSQ_W  = 2 * RAD_W;
  localparam int D2_W   = 64;
  localparam int TIER_W = 2;

  localparam int MOD_STAGES = TICK_W;
  localparam int HASH_START = MOD_STAGES - HASH_W;

  localparam logic [SIZE_W-1:0] SIZE_FALLBACK = 24'd9600;
  localparam logic [HASH_W-1:0] HASH_MUL_X    = 32'd73856093;
  localparam logic [HASH_W-1:0] HASH_MUL_Z    = 32'd19349663;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_SIZE       = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_X          = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_Z          = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INDIVIDUAL_RADIUS = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COHORT_RADIUS     = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INDIVIDUAL_PERIOD = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COHORT_PERIOD     = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_AGGREGATE_PERIOD  = 4'd7;

  localparam logic [TIER_W-1:0] TIER_INDIVIDUAL = 2'd0;
  localparam logic [TIER_W-1:0] TIER_COHORT     = 2'd1;
  localparam logic [TIER_W-1:0] TIER_AGGREGATE  = 2'd2;

  typedef enum logic [1:0] {CNT_IDLE, CNT_LOAD, CNT_RUN, CNT_DONE} cnt_state_t;

  typedef struct packed {
    logic [SIZE_W-1:0] tile_side;
    logic [EXT_W-1:0]  extent_x;
    logic [EXT_W-1:0]  extent_z;
    logic [RAD_W-1:0]  near_radius;
    logic [RAD_W-1:0]  mid_radius;
    logic [PER_W-1:0]  individual_period;
    logic [PER_W-1:0]  cohort_period;
    logic [PER_W-1:0]  aggregate_period;
  } cfg_t;

  typedef struct packed {
    logic [TIER_W-1:0] tier;
    logic [PER_W-1:0]  period;
    logic [HASH_W-1:0] hash;
    logic [TICK_W-1:0] tick;
    logic [CEN_W-1:0]  center_x;
    logic [CEN_W-1:0]  center_z;
  } sched_item_t;

  function automatic logic [PER_W-1:0] rem_step(logic [PER_W-1:0] r, logic b,
                                                logic [PER_W-1:0] p);
    logic [PER_W:0] t;
    t = {r, b};
    if (t >= {1'b0, p}) t = t - {1'b0, p};
    return t[PER_W-1:0];
  endfunction

endpackage
`default_nettype wire

[hdl/rlts_count.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// rlts_count
// Grid column and row counts: ceil(extent / size), at least one, capped,
// by a bit-serial restoring divider for both axes at once.
// ---------------------------------------------------------------------------
module rlts_count
  import rlts_pkg::*;
#(
  parameter int MAX_REGIONS_PER_AXIS = MAX_REGIONS_DEF,
  parameter int CNT_W = $clog2(MAX_REGIONS_PER_AXIS + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [SIZE_W-1:0] size,
  input  wire logic [EXT_W-1:0]  extent_x,
  input  wire logic [EXT_W-1:0]  extent_z,
  output logic                   busy,
  output logic [CNT_W-1:0]       column_count,
  output logic [CNT_W-1:0]       row_count
);

  localparam int STEP_W = $clog2(NUM_W);

  cnt_state_t state, state_next;
  logic [STEP_W-1:0] step;
  logic [NUM_W-1:0]  numx, numz, qx, qz;
  logic [SIZE_W-1:0] remx, remz;
  logic [SIZE_W:0]   tx, tz;
  logic              bx, bz;

  function automatic logic [CNT_W-1:0] finish(logic [NUM_W-1:0] q);
    if (q == '0) return CNT_W'(1);
    if (q > NUM_W'(MAX_REGIONS_PER_AXIS)) return CNT_W'(MAX_REGIONS_PER_AXIS);
    return q[CNT_W-1:0];
  endfunction

  always_comb begin
    state_next = state;
    if (start) begin
      state_next = CNT_LOAD;
    end else begin
      unique case (state)
        CNT_IDLE: state_next = CNT_IDLE;
        CNT_LOAD: state_next = CNT_RUN;
        CNT_RUN:  if (step == STEP_W'(NUM_W - 1)) state_next = CNT_DONE;
        CNT_DONE: state_next = CNT_IDLE;
        default:  state_next = CNT_IDLE;
      endcase
    end
  end

  assign busy = (state != CNT_IDLE);
  assign tx = {remx, numx[NUM_W-1]};
  assign tz = {remz, numz[NUM_W-1]};
  assign bx = (tx >= {1'b0, size});
  assign bz = (tz >= {1'b0, size});

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= CNT_IDLE;
      column_count <= CNT_W'(1);
      row_count    <= CNT_W'(1);
    end else begin
      state <= state_next;
      if (state == CNT_DONE) begin
        column_count <= finish(qx);
        row_count    <= finish(qz);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == CNT_LOAD) begin
      numx <= NUM_W'(extent_x) + NUM_W'(size) - NUM_W'(1);
      numz <= NUM_W'(extent_z) + NUM_W'(size) - NUM_W'(1);
      remx <= '0;
      remz <= '0;
      qx   <= '0;
      qz   <= '0;
      step <= '0;
    end else if (state == CNT_RUN) begin
      numx <= {numx[NUM_W-2:0], 1'b0};
      numz <= {numz[NUM_W-2:0], 1'b0};
      remx <= bx ? SIZE_W'(tx - {1'b0, size}) : tx[SIZE_W-1:0];
      remz <= bz ? SIZE_W'(tz - {1'b0, size}) : tz[SIZE_W-1:0];
      qx   <= {qx[NUM_W-2:0], bx};
      qz   <= {qz[NUM_W-2:0], bz};
      step <= step + STEP_W'(1);
    end
  end

endmodule
`default_nettype wire

[hdl/rlts_geom.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// rlts_geom
// Eight-stage front pipe: clamp, region span, hash, axis gaps, squared
// distance, tier and period.
// ---------------------------------------------------------------------------
module rlts_geom
  import rlts_pkg::*;
#(
  parameter int MAX_REGIONS_PER_AXIS = MAX_REGIONS_DEF,
  parameter int CNT_W = $clog2(MAX_REGIONS_PER_AXIS + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic               in_valid,
  input  wire logic signed [15:0] region_x,
  input  wire logic signed [15:0] region_z,
  input  wire logic signed [31:0] observer_x,
  input  wire logic signed [31:0] observer_z,
  input  wire logic [TICK_W-1:0]  tick,
  input  wire cfg_t               cfg,
  input  wire logic [SIZE_W-1:0]  size,
  input  wire logic [CNT_W-1:0]   column_count,
  input  wire logic [CNT_W-1:0]   row_count,
  output logic                    out_valid,
  output sched_item_t             out_item
);

  localparam int AW   = CNT_W + SIZE_W;
  localparam int HW   = (AW + 1 > NUM_W) ? AW + 1 : NUM_W;
  localparam int XW   = ((HW > 32) ? HW : 32) + 2;
  localparam int GW   = XW - 1;

  function automatic logic [CNT_W-1:0] clamp(logic signed [15:0] c,
                                             logic [CNT_W-1:0] cnt);
    logic [CNT_W-1:0] lim;
    lim = cnt - CNT_W'(1);
    if (c < 0) return '0;
    if ({1'b0, c} > 17'(lim)) return lim;
    return c[CNT_W-1:0];
  endfunction

  function automatic logic [HW-1:0] span_hi(logic [AW-1:0] a, logic [SIZE_W-1:0] s,
                                            logic [EXT_W-1:0] e);
    logic [HW-1:0] b;
    b = HW'(a) + HW'(s);
    if (b > HW'(e)) b = HW'(e);
    if (b < HW'(a)) b = HW'(a);
    return b;
  endfunction

  function automatic logic [GW-1:0] gap(logic signed [31:0] o, logic [AW-1:0] lo,
                                        logic [HW-1:0] hi);
    logic signed [XW-1:0] oe, le, he, d;
    oe = XW'(o);
    le = $signed(XW'(lo));
    he = $signed(XW'(hi));
    if (oe < le) d = le - oe;
    else if (oe > he) d = oe - he;
    else d = '0;
    return d[GW-1:0];
  endfunction

  function automatic logic [PER_W-1:0] per(logic [PER_W-1:0] p);
    return (p == '0) ? PER_W'(1) : p;
  endfunction

  logic              v1, v2, v3, v4, v5, v6, v7, v8;
  logic [CNT_W-1:0]  cx1, cz1;
  logic signed [31:0] ox1, oz1, ox2, oz2, ox3, oz3;
  logic [TICK_W-1:0] tk1, tk2, tk3, tk4, tk5, tk6, tk7, tk8;
  logic [AW-1:0]     ax2, az2, ax3, az3;
  logic [HW-1:0]     bx3, bz3;
  logic [HASH_W-1:0] h2, h3, h4, h5, h6, h7, h8;
  logic [GW-1:0]     gx4, gz4;
  logic [CEN_W-1:0]  cx4, cz4, cx5, cz5, cx6, cz6, cx7, cz7, cx8, cz8;
  logic [D2_W-1:0]   sqlx5, sqlz5, sqx6, sqz6, d27;
  logic [31:0]       crx5, crz5;
  logic [RSQ_W-1:0]  r0sq5, r1sq5, r0sq6, r1sq6, r0sq7, r1sq7;
  logic [RAD_W-1:0]  r1;
  logic [D2_W:0]     sum7;
  logic [TIER_W-1:0] tier8;
  logic [PER_W-1:0]  per8;
  logic [HW:0]       cenx, cenz;

  assign r1   = (cfg.mid_radius < cfg.near_radius) ?
                cfg.near_radius : cfg.mid_radius;
  assign cenx = (HW+1)'(ax3) + (HW+1)'(bx3);
  assign cenz = (HW+1)'(az3) + (HW+1)'(bz3);
  assign sum7 = {1'b0, sqx6} + {1'b0, sqz6};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
      v5 <= 1'b0; v6 <= 1'b0; v7 <= 1'b0; v8 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid; v2 <= v1; v3 <= v2; v4 <= v3;
      v5 <= v4; v6 <= v5; v7 <= v6; v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx1 <= clamp(region_x, column_count);
      cz1 <= clamp(region_z, row_count);
      ox1 <= observer_x;
      oz1 <= observer_z;
      tk1 <= tick;

      ax2 <= AW'(cx1) * AW'(size);
      az2 <= AW'(cz1) * AW'(size);
      h2  <= (HASH_W'(cx1) * HASH_MUL_X) ^ (HASH_W'(cz1) * HASH_MUL_Z);
      ox2 <= ox1; oz2 <= oz1; tk2 <= tk1;

      ax3 <= ax2; az3 <= az2;
      bx3 <= span_hi(ax2, size, cfg.extent_x);
      bz3 <= span_hi(az2, size, cfg.extent_z);
      ox3 <= ox2; oz3 <= oz2; tk3 <= tk2; h3 <= h2;

      gx4 <= gap(ox3, ax3, bx3);
      gz4 <= gap(oz3, az3, bz3);
      cx4 <= cenx[CEN_W-1:0];
      cz4 <= cenz[CEN_W-1:0];
      tk4 <= tk3; h4 <= h3;

      sqlx5 <= D2_W'(gx4[31:0]) * D2_W'(gx4[31:0]);
      sqlz5 <= D2_W'(gz4[31:0]) * D2_W'(gz4[31:0]);
      crx5  <= 32'(32'(gx4[GW-1:32]) * gx4[31:0]);
      crz5  <= 32'(32'(gz4[GW-1:32]) * gz4[31:0]);
      r0sq5 <= RSQ_W'(cfg.near_radius) * RSQ_W'(cfg.near_radius);
      r1sq5 <= RSQ_W'(r1) * RSQ_W'(r1);
      cx5 <= cx4; cz5 <= cz4; tk5 <= tk4; h5 <= h4;

      sqx6 <= sqlx5 + {crx5[30:0], 33'b0};
      sqz6 <= sqlz5 + {crz5[30:0], 33'b0};
      r0sq6 <= r0sq5; r1sq6 <= r1sq5;
      cx6 <= cx5; cz6 <= cz5; tk6 <= tk5; h6 <= h5;

      d27 <= sum7[D2_W] ? '1 : sum7[D2_W-1:0];
      r0sq7 <= r0sq6; r1sq7 <= r1sq6;
      cx7 <= cx6; cz7 <= cz6; tk7 <= tk6; h7 <= h6;

      if (d27 <= D2_W'(r0sq7)) begin
        tier8 <= TIER_INDIVIDUAL;
        per8  <= per(cfg.individual_period);
      end else if (d27 <= D2_W'(r1sq7)) begin
        tier8 <= TIER_COHORT;
        per8  <= per(cfg.cohort_period);
      end else begin
        tier8 <= TIER_AGGREGATE;
        per8  <= per(cfg.aggregate_period);
      end
      cx8 <= cx7; cz8 <= cz7; tk8 <= tk7; h8 <= h7;
    end
  end

  assign out_valid         = v8;
  assign out_item.tier     = tier8;
  assign out_item.period   = per8;
  assign out_item.hash     = h8;
  assign out_item.tick     = tk8;
  assign out_item.center_x = cx8;
  assign out_item.center_z = cz8;

endmodule
`default_nettype wire

[hdl/rlts_mod_pipe.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// rlts_mod_pipe
// Pipelined restoring remainder: tick mod period and hash mod period,
// one dividend bit per stage.
// ---------------------------------------------------------------------------
module rlts_mod_pipe
  import rlts_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire logic        in_valid,
  input  wire sched_item_t in_item,
  output logic             out_valid,
  output sched_item_t      out_item,
  output logic [PER_W-1:0] out_tick_rem,
  output logic [PER_W-1:0] out_hash_rem
);

  logic              vld  [MOD_STAGES];
  sched_item_t       item [MOD_STAGES];
  logic [PER_W-1:0]  trem [MOD_STAGES];
  logic [PER_W-1:0]  hrem [MOD_STAGES];

  for (genvar k = 0; k < MOD_STAGES; k++) begin : g_stage
    logic             pv;
    sched_item_t      pi;
    logic [PER_W-1:0] pt, ph;

    if (k == 0) begin : g_first
      assign pv = in_valid;
      assign pi = in_item;
      assign pt = '0;
      assign ph = '0;
    end else begin : g_next
      assign pv = vld[k-1];
      assign pi = item[k-1];
      assign pt = trem[k-1];
      assign ph = hrem[k-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        item[k] <= pi;
        trem[k] <= rem_step(pt, pi.tick[MOD_STAGES-1-k], pi.period);
      end
    end

    if (k >= HASH_START) begin : g_hash
      always_ff @(posedge clk) begin
        if (en) begin
          hrem[k] <= rem_step(ph, pi.hash[MOD_STAGES-1-k], pi.period);
        end
      end
    end else begin : g_hold
      always_ff @(posedge clk) begin
        if (en) begin
          hrem[k] <= ph;
        end
      end
    end
  end

  assign out_valid    = vld[MOD_STAGES-1];
  assign out_item     = item[MOD_STAGES-1];
  assign out_tick_rem = trem[MOD_STAGES-1];
  assign out_hash_rem = hrem[MOD_STAGES-1];

endmodule
`default_nettype wire

[hdl/region_lod_tick_scheduler.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// region_lod_tick_scheduler
// Level-of-detail tier, period, phase and due flag for one grid region.
// ---------------------------------------------------------------------------
// Takes one region beat per clock while s_tready is high (no stall on
// m_tready and no grid recount) and returns one result beat per region,
// in order: eight stages of geometry and tier selection followed by a
// 64-stage remainder pipe, one tick bit per stage. The whole pipe
// advances together; it holds while a result waits on m_tready. A write of
// the region size or of either extent recomputes the grid counts with a
// bit-serial divider, and s_tready stays low while it runs.
module region_lod_tick_scheduler
  import rlts_pkg::*;
#(
  parameter int MAX_REGIONS_PER_AXIS = MAX_REGIONS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // region_x[15:0], region_z[31:16], observer_x[63:32], observer_z[95:64],
  // tick[159:96]
  input  wire logic [159:0]          s_tdata,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // tier[1:0], tier_period[33:2], phase[65:34], due_now[66],
  // center_x[95:67], center_z[124:96], zero[127:125]
  output logic [127:0]               m_tdata,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CNT_W = $clog2(MAX_REGIONS_PER_AXIS + 1);

  cfg_t              cfg;
  logic [SIZE_W-1:0] size;
  logic              recount, busy, en, geo_valid, out_valid;
  logic [CNT_W-1:0]  column_count, row_count;
  sched_item_t       geo_item, out_item;
  logic [PER_W-1:0]  tick_rem, hash_rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tile_side         <= SIZE_W'(9600);
      cfg.extent_x          <= '0;
      cfg.extent_z          <= '0;
      cfg.near_radius       <= RAD_W'(19200);
      cfg.mid_radius        <= RAD_W'(76800);
      cfg.individual_period <= PER_W'(1);
      cfg.cohort_period     <= PER_W'(1);
      cfg.aggregate_period  <= PER_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_REGION_SIZE:       cfg.tile_side         <= cfg_data[SIZE_W-1:0];
        REG_EXTENT_X:          cfg.extent_x          <= cfg_data[EXT_W-1:0];
        REG_EXTENT_Z:          cfg.extent_z          <= cfg_data[EXT_W-1:0];
        REG_INDIVIDUAL_RADIUS: cfg.near_radius       <= cfg_data[RAD_W-1:0];
        REG_COHORT_RADIUS:     cfg.mid_radius        <= cfg_data[RAD_W-1:0];
        REG_INDIVIDUAL_PERIOD: cfg.individual_period <= cfg_data;
        REG_COHORT_PERIOD:     cfg.cohort_period     <= cfg_data;
        REG_AGGREGATE_PERIOD:  cfg.aggregate_period  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign recount = cfg_we && (cfg_index == REG_REGION_SIZE ||
                              cfg_index == REG_EXTENT_X ||
                              cfg_index == REG_EXTENT_Z);
  assign size = (cfg.tile_side == '0) ? SIZE_FALLBACK : cfg.tile_side;

  assign en       = !out_valid || m_tready;
  assign s_tready = en && !busy;

  rlts_count #(
    .MAX_REGIONS_PER_AXIS(MAX_REGIONS_PER_AXIS),
    .CNT_W(CNT_W)
  ) u_count (
    .clk, .rst,
    .start(recount),
    .size,
    .extent_x(cfg.extent_x),
    .extent_z(cfg.extent_z),
    .busy,
    .column_count,
    .row_count
  );

  rlts_geom #(
    .MAX_REGIONS_PER_AXIS(MAX_REGIONS_PER_AXIS),
    .CNT_W(CNT_W)
  ) u_geom (
    .clk, .rst, .en,
    .in_valid(s_tvalid && !busy),
    .region_x($signed(s_tdata[15:0])),
    .region_z($signed(s_tdata[31:16])),
    .observer_x($signed(s_tdata[63:32])),
    .observer_z($signed(s_tdata[95:64])),
    .tick(s_tdata[159:96]),
    .cfg,
    .size,
    .column_count,
    .row_count,
    .out_valid(geo_valid),
    .out_item(geo_item)
  );

  rlts_mod_pipe u_mod (
    .clk, .rst, .en,
    .in_valid(geo_valid),
    .in_item(geo_item),
    .out_valid,
    .out_item,
    .out_tick_rem(tick_rem),
    .out_hash_rem(hash_rem)
  );

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, out_item.center_z, out_item.center_x,
                     tick_rem == hash_rem, hash_rem, out_item.period,
                     out_item.tier};

endmodule
`default_nettype wire

[hdl/rlts_checker.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// rlts_checker
// Port-level checks of the region LOD tick scheduler, bound to the top.
// ---------------------------------------------------------------------------
module rlts_checker
  import rlts_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  s_tvalid,
  input wire logic                  s_tready,
  input wire logic [159:0]          s_tdata,
  input wire logic                  m_tvalid,
  input wire logic                  m_tready,
  input wire logic [127:0]          m_tdata,
  input wire logic                  cfg_we,
  input wire logic [CFG_IDX_W-1:0]  cfg_index,
  input wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic unused;
  assign unused = s_tvalid ^ (^s_tdata) ^ (^cfg_data);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  a_tier: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[1:0] != 2'd3)
    else $error("tier out of range");

  a_phase: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[33:2] != 32'd0 && m_tdata[65:34] < m_tdata[33:2])
    else $error("phase not below period");

  a_recount: assert property (@(posedge clk) disable iff (rst)
    cfg_we && (cfg_index == REG_REGION_SIZE || cfg_index == REG_EXTENT_X ||
               cfg_index == REG_EXTENT_Z) |=> !s_tready)
    else $error("input open during grid recount");

endmodule

bind region_lod_tick_scheduler rlts_checker u_rlts_checker (.*);
`default_nettype wire
